// ===== rtl/obstacle_avoid_motor_sequencer_defines.svh =====
// Assertion macros used by the bound checker file.
`ifndef OBSTACLE_AVOID_MOTOR_SEQUENCER_DEFINES_SVH
`define OBSTACLE_AVOID_MOTOR_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OAMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define OAMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/oams_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package oams_pkg;

  typedef enum logic [3:0] {
    PH_WAIT       = 4'd0,
    PH_FWD        = 4'd1,
    PH_ESC_REV    = 4'd2,
    PH_ESC_TURN   = 4'd3,
    PH_SHORT_REV  = 4'd4,
    PH_TURN_CLEAR = 4'd5,
    PH_EXTRA      = 4'd6,
    PH_REV_CLEAR  = 4'd7,
    PH_TIMED_TURN = 4'd8,
    PH_PAUSE      = 4'd9
  } phase_t;

  typedef enum logic [3:0] {
    CL_NONE = 4'd0,
    CL_N    = 4'd1,
    CL_NW   = 4'd2,
    CL_NE   = 4'd3,
    CL_E    = 4'd4,
    CL_W    = 4'd5,
    CL_SL   = 4'd6,
    CL_SR   = 4'd7,
    CL_SUR  = 4'd8
  } class_t;

  localparam logic [7:0] PINS_STOP  = 8'h00;
  localparam logic [7:0] PINS_FWD   = 8'h66;
  localparam logic [7:0] PINS_REV   = 8'h99;
  localparam logic [7:0] PINS_LEFT  = 8'h55;
  localparam logic [7:0] PINS_RIGHT = 8'hAA;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_REV   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_REV    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_TURN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUARTER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_WIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 3'd6;

  localparam logic [CFG_DATA_W-1:0] RST_SHORT_REV  = 16'd150;
  localparam logic [CFG_DATA_W-1:0] RST_LONG_REV   = 16'd200;
  localparam logic [CFG_DATA_W-1:0] RST_EXTRA_TURN = 16'd300;
  localparam logic [CFG_DATA_W-1:0] RST_QUARTER    = 16'd400;
  localparam logic [CFG_DATA_W-1:0] RST_HALF       = 16'd450;
  localparam logic [CFG_DATA_W-1:0] RST_REPEAT_WIN = 16'd500;
  localparam logic [CFG_DATA_W-1:0] RST_SETTLE     = 16'd500;

  // Sorts an obstacle from the five sensors and the previous class.
  function automatic class_t classify(input logic f, input logic l, input logic r,
                                      input logic sl, input logic sr,
                                      input class_t last);
    class_t c;
    c = CL_NONE;
    priority if ((f && !r && !l) || (r && l)) begin
      priority if (!sr && !sl) c = CL_N;
      else if (sr && sl) c = CL_SUR;
      else if (sl) c = (last == CL_SR) ? CL_SUR : CL_SL;
      else c = (last == CL_SL) ? CL_SUR : CL_SR;
    end else if (r && !l) begin
      priority if (!sr && !sl) c = CL_NE;
      else if (sr && !sl) c = CL_E;
      else c = CL_SUR;
    end else if (l && !r) begin
      priority if (!sr && !sl) c = CL_NW;
      else if (sl && !sr) c = CL_W;
      else c = CL_SUR;
    end else begin
      c = CL_NONE;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/obstacle_avoid_motor_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Obstacle avoidance motor sequencer.
// Each beat on the in_ channel is one millisecond tick carrying the five IR
// blocked flags and the start button level. For every input beat the block
// produces exactly one beat on the out_ channel with the eight motor pins,
// the class of the latest obstacle and the phase after that tick.
// The result is held in the single result register and appears in the
// cycle after the input beat is accepted; while the receiver takes each
// result, a new input beat can be accepted in every cycle, one tick per cycle.
// When the receiver stalls, the result waits in the output register and
// in_tready falls until it is taken; input beats then wait upstream.
// Timing registers are written over the cfg_ channel, which is always ready;
// they should only be changed while no tick is in flight.
// Reset returns the sequencer to the waiting phase with the tick counter,
// the obstacle history and the timer cleared, the timing registers back at
// their default values and the output register empty.
module obstacle_avoid_motor_sequencer
  import oams_pkg::*;
#(
  parameter int unsigned DURATION_WIDTH = 16,
  parameter int unsigned TICK_WIDTH     = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  // [0] front_blocked, [1] left_blocked, [2] right_blocked,
  // [3] side_left_blocked, [4] side_right_blocked, [5] start_button, [7:6] zero
  input  wire logic [7:0]            in_tdata,
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  // [7:0] motor_pins, [11:8] obstacle_class, [15:12] phase_code
  output      logic [15:0]           out_tdata,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef struct packed {
    phase_t                    ph;
    logic [DURATION_WIDTH-1:0] tmr;
    logic                      tl;
  } plan_t;

  logic [CFG_DATA_W-1:0] short_rev_r, long_rev_r, extra_turn_r, quarter_r;
  logic [CFG_DATA_W-1:0] half_r, repeat_win_r, settle_r;

  phase_t                    phase_r, phase_nxt;
  logic [DURATION_WIDTH-1:0] timer_r, timer_nxt;
  logic [TICK_WIDTH-1:0]     tick_r, last_time_r, last_time_nxt;
  class_t                    last_class_r, last_class_nxt;
  class_t                    cur_class_r, cur_class_nxt;
  logic                      turn_left_r, turn_left_nxt;

  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic [7:0]  pins_nxt;

  logic f, l, r, sl, sr, start;
  logic in_fire, any_front, parity_left, tmr_done;
  logic [DURATION_WIDTH-1:0] tmr_dec;
  logic [TICK_WIDTH-1:0]     fc_diff;
  class_t                    fc_class;
  plan_t                     fc_plan, bc_plan, cur_plan, plan;
  logic                      fc_hit;

  function automatic plan_t begin_plan(input class_t c, input plan_t cur,
                                       input logic [DURATION_WIDTH-1:0] srev,
                                       input logic [DURATION_WIDTH-1:0] settle);
    plan_t p;
    p = cur;
    unique case (c)
      CL_N, CL_W, CL_E: begin
        p.ph  = PH_SHORT_REV;
        p.tmr = srev;
      end
      CL_NW: begin
        p.ph = PH_TURN_CLEAR;
        p.tl = 1'b0;
      end
      CL_NE: begin
        p.ph = PH_TURN_CLEAR;
        p.tl = 1'b1;
      end
      CL_SL, CL_SR, CL_SUR: p.ph = PH_REV_CLEAR;
      default: begin
        p.ph  = PH_PAUSE;
        p.tmr = settle;
      end
    endcase
    return p;
  endfunction

  assign f     = in_tdata[0];
  assign l     = in_tdata[1];
  assign r     = in_tdata[2];
  assign sl    = in_tdata[3];
  assign sr    = in_tdata[4];
  assign start = in_tdata[5];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign any_front   = f || l || r;
  assign parity_left = ~tick_r[0];
  assign tmr_done    = timer_r <= DURATION_WIDTH'(1);
  assign tmr_dec     = timer_r - DURATION_WIDTH'(1);

  assign cur_plan = '{ph: phase_r, tmr: timer_r, tl: turn_left_r};
  assign fc_class = classify(f, l, r, sl, sr, last_class_r);
  assign fc_diff  = tick_r - last_time_r;
  assign fc_hit   = fc_diff <= TICK_WIDTH'(repeat_win_r);

  always_comb begin
    bc_plan = begin_plan(cur_class_r, cur_plan, DURATION_WIDTH'(short_rev_r),
                         DURATION_WIDTH'(settle_r));
    if (!any_front) begin
      fc_plan    = cur_plan;
      fc_plan.ph = PH_FWD;
    end else if (fc_hit) begin
      fc_plan     = cur_plan;
      fc_plan.ph  = PH_ESC_REV;
      fc_plan.tmr = DURATION_WIDTH'(long_rev_r);
    end else begin
      fc_plan = begin_plan(fc_class, cur_plan, DURATION_WIDTH'(short_rev_r),
                           DURATION_WIDTH'(settle_r));
    end
  end

  // Next state
  always_comb begin
    logic run_fc;
    run_fc         = 1'b0;
    plan           = cur_plan;
    last_time_nxt  = last_time_r;
    last_class_nxt = last_class_r;
    cur_class_nxt  = cur_class_r;

    unique case (phase_r)
      PH_WAIT: run_fc = start;
      PH_FWD:  run_fc = 1'b1;
      PH_ESC_REV: begin
        if (tmr_done) begin
          plan = '{ph: PH_ESC_TURN, tmr: DURATION_WIDTH'(half_r), tl: parity_left};
        end else begin
          plan.tmr = tmr_dec;
        end
      end
      PH_ESC_TURN: begin
        if (tmr_done) begin
          plan = bc_plan;
        end else begin
          plan.tmr = tmr_dec;
        end
      end
      PH_SHORT_REV: begin
        if (tmr_done) begin
          priority if (cur_class_r == CL_N) begin
            plan.ph = PH_TURN_CLEAR;
            plan.tl = parity_left;
          end else if (cur_class_r == CL_W || cur_class_r == CL_E) begin
            plan = '{ph: PH_TIMED_TURN, tmr: DURATION_WIDTH'(quarter_r),
                     tl: (cur_class_r == CL_E)};
          end else begin
            plan.ph  = PH_PAUSE;
            plan.tmr = DURATION_WIDTH'(settle_r);
          end
        end else begin
          plan.tmr = tmr_dec;
        end
      end
      PH_TURN_CLEAR: begin
        if (!(turn_left_r ? r : l)) begin
          plan.ph  = PH_EXTRA;
          plan.tmr = DURATION_WIDTH'(extra_turn_r);
        end
      end
      PH_EXTRA, PH_TIMED_TURN: begin
        if (tmr_done) begin
          plan.ph  = PH_PAUSE;
          plan.tmr = DURATION_WIDTH'(settle_r);
        end else begin
          plan.tmr = tmr_dec;
        end
      end
      PH_REV_CLEAR: begin
        if (!(any_front && sl && sr)) begin
          plan.ph  = PH_TIMED_TURN;
          plan.tmr = DURATION_WIDTH'(quarter_r);
          priority if (cur_class_r == CL_SL) plan.tl = 1'b0;
          else if (cur_class_r == CL_SR) plan.tl = 1'b1;
          else plan.tl = parity_left;
        end
      end
      PH_PAUSE: begin
        if (tmr_done) begin
          run_fc = 1'b1;
        end else begin
          plan.tmr = tmr_dec;
        end
      end
      default: plan.ph = PH_WAIT;
    endcase

    if (run_fc) begin
      plan = fc_plan;
      if (any_front) begin
        cur_class_nxt  = fc_class;
        last_class_nxt = fc_class;
        last_time_nxt  = tick_r;
      end
    end

    phase_nxt     = plan.ph;
    timer_nxt     = plan.tmr;
    turn_left_nxt = plan.tl;
  end

  // Outputs
  always_comb begin
    unique case (phase_nxt)
      PH_FWD: pins_nxt = PINS_FWD;
      PH_ESC_REV, PH_SHORT_REV, PH_REV_CLEAR: pins_nxt = PINS_REV;
      PH_ESC_TURN, PH_TURN_CLEAR, PH_EXTRA, PH_TIMED_TURN:
        pins_nxt = turn_left_nxt ? PINS_LEFT : PINS_RIGHT;
      default: pins_nxt = PINS_STOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_rev_r  <= RST_SHORT_REV;
      long_rev_r   <= RST_LONG_REV;
      extra_turn_r <= RST_EXTRA_TURN;
      quarter_r    <= RST_QUARTER;
      half_r       <= RST_HALF;
      repeat_win_r <= RST_REPEAT_WIN;
      settle_r     <= RST_SETTLE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SHORT_REV:  short_rev_r  <= cfg_data;
        CFG_LONG_REV:   long_rev_r   <= cfg_data;
        CFG_EXTRA_TURN: extra_turn_r <= cfg_data;
        CFG_QUARTER:    quarter_r    <= cfg_data;
        CFG_HALF:       half_r       <= cfg_data;
        CFG_REPEAT_WIN: repeat_win_r <= cfg_data;
        CFG_SETTLE:     settle_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT;
      timer_r      <= '0;
      tick_r       <= '0;
      last_time_r  <= '0;
      last_class_r <= CL_NONE;
      cur_class_r  <= CL_NONE;
      turn_left_r  <= 1'b0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      timer_r      <= timer_nxt;
      tick_r       <= tick_r + TICK_WIDTH'(1);
      last_time_r  <= last_time_nxt;
      last_class_r <= last_class_nxt;
      cur_class_r  <= cur_class_nxt;
      turn_left_r  <= turn_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {phase_nxt, cur_class_nxt, pins_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/oams_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "obstacle_avoid_motor_sequencer_defines.svh"

module oams_checker
  import oams_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  logic   [7:0] pins;
  class_t       cls;
  phase_t       ph;
  logic         in_fire, out_stall, ph_idle, ph_free;

  assign pins = out_tdata[7:0];
  assign cls  = class_t'(out_tdata[11:8]);
  assign ph   = phase_t'(out_tdata[15:12]);

  assign in_fire   = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign ph_idle   = ph == PH_WAIT || ph == PH_PAUSE;
  assign ph_free   = ph == PH_WAIT || ph == PH_FWD;

  `OAMS_ASSERT_NXT(a_follow, in_fire, out_tvalid, "accepted beat gave no result")

  `OAMS_ASSERT_NXT(a_hold, out_stall, out_tvalid && $stable(out_tdata), "held beat changed")

  `OAMS_ASSERT_NOW(a_stop, out_tvalid && ph_idle, pins == PINS_STOP, "motors not stopped")

  `OAMS_ASSERT_NOW(a_fwd, out_tvalid && ph == PH_FWD, pins == PINS_FWD, "forward pins wrong")

  `OAMS_ASSERT_NOW(a_class, out_tvalid && cls == CL_NONE, ph_free, "manoeuvre without a class")

endmodule

bind obstacle_avoid_motor_sequencer oams_checker u_oams_checker (.*);

`default_nettype wire

// ===== sim/obstacle_avoid_motor_sequencer_checker.sv =====
`timescale 1ns / 1ps

module obstacle_avoid_motor_sequencer_checker
  import oams_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [15:0]           out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           mismatches,
  output int unsigned           pending,
  output int unsigned           ticks_checked,
  output logic [9:0]            phases_seen,
  output logic [8:0]            classes_seen
);

  // Laid out exactly as the result beat, pins in the lowest byte.
  typedef struct packed {
    phase_t     phase_code;
    class_t     obstacle;
    logic [7:0] pins;
  } motion_t;

  motion_t motion_q[$];

  logic [15:0] t_short_rev, t_long_rev, t_extra, t_quarter, t_half, t_window, t_settle;

  phase_t      seq_phase;
  logic [15:0] phase_left;
  logic [31:0] tick_no;
  logic [31:0] last_hit;
  class_t      prev_class;
  class_t      cur_class;
  logic        turn_left_q;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t: mismatch: %s", $time, what);
    end
  endtask

  function automatic void start_timed(input phase_t p, input logic [15:0] dur);
    seq_phase = p;
    phase_left = dur;
  endfunction

  function automatic logic timer_expired();
    if (phase_left <= 16'd1) begin
      return 1'b1;
    end
    phase_left = phase_left - 16'd1;
    return 1'b0;
  endfunction

  function automatic class_t sort_obstacle(input logic f, input logic l, input logic r,
                                           input logic sl, input logic sr);
    logic ahead;
    ahead = (f && !l && !r) || (l && r);
    if (ahead) begin
      case ({sl, sr})
        2'b00: return CL_N;
        2'b11: return CL_SUR;
        2'b10: return (prev_class == CL_SR) ? CL_SUR : CL_SL;
        default: return (prev_class == CL_SL) ? CL_SUR : CL_SR;
      endcase
    end
    if (r && !l) begin
      return sl ? CL_SUR : (sr ? CL_E : CL_NE);
    end
    if (l && !r) begin
      return sr ? CL_SUR : (sl ? CL_W : CL_NW);
    end
    return CL_NONE;
  endfunction

  function automatic void begin_manoeuvre();
    case (cur_class)
      CL_N, CL_W, CL_E: start_timed(PH_SHORT_REV, t_short_rev);
      CL_NW: begin
        turn_left_q = 1'b0;
        seq_phase = PH_TURN_CLEAR;
      end
      CL_NE: begin
        turn_left_q = 1'b1;
        seq_phase = PH_TURN_CLEAR;
      end
      CL_SL, CL_SR, CL_SUR: seq_phase = PH_REV_CLEAR;
      default: start_timed(PH_PAUSE, t_settle);
    endcase
  endfunction

  function automatic void finish_short_reverse(input logic [31:0] now);
    case (cur_class)
      CL_N: begin
        turn_left_q = ~now[0];
        seq_phase = PH_TURN_CLEAR;
      end
      CL_W: begin
        turn_left_q = 1'b0;
        start_timed(PH_TIMED_TURN, t_quarter);
      end
      CL_E: begin
        turn_left_q = 1'b1;
        start_timed(PH_TIMED_TURN, t_quarter);
      end
      default: start_timed(PH_PAUSE, t_settle);
    endcase
  endfunction

  function automatic void check_path(input logic [5:0] s, input logic [31:0] now);
    logic [31:0] gap;
    if (s[2:0] == 3'b000) begin
      seq_phase = PH_FWD;
      return;
    end
    cur_class = sort_obstacle(s[0], s[1], s[2], s[3], s[4]);
    prev_class = cur_class;
    gap = now - last_hit;
    last_hit = now;
    if (gap <= {16'd0, t_window}) begin
      start_timed(PH_ESC_REV, t_long_rev);
    end else begin
      begin_manoeuvre();
    end
  endfunction

  function automatic motion_t predict_motion(input logic [5:0] s);
    logic [31:0] now;
    motion_t     m;
    now = tick_no;
    case (seq_phase)
      PH_WAIT: if (s[5]) check_path(s, now);
      PH_FWD: check_path(s, now);
      PH_ESC_REV: if (timer_expired()) begin
        turn_left_q = ~now[0];
        start_timed(PH_ESC_TURN, t_half);
      end
      PH_ESC_TURN: if (timer_expired()) begin_manoeuvre();
      PH_SHORT_REV: if (timer_expired()) finish_short_reverse(now);
      PH_TURN_CLEAR: if (!(turn_left_q ? s[2] : s[1])) start_timed(PH_EXTRA, t_extra);
      PH_EXTRA, PH_TIMED_TURN: if (timer_expired()) start_timed(PH_PAUSE, t_settle);
      PH_REV_CLEAR: if (!((s[0] || s[1] || s[2]) && s[3] && s[4])) begin
        if (cur_class == CL_SL) begin
          turn_left_q = 1'b0;
        end else if (cur_class == CL_SR) begin
          turn_left_q = 1'b1;
        end else begin
          turn_left_q = ~now[0];
        end
        start_timed(PH_TIMED_TURN, t_quarter);
      end
      PH_PAUSE: if (timer_expired()) check_path(s, now);
      default: seq_phase = PH_WAIT;
    endcase
    case (seq_phase)
      PH_FWD: m.pins = PINS_FWD;
      PH_ESC_REV, PH_SHORT_REV, PH_REV_CLEAR: m.pins = PINS_REV;
      PH_ESC_TURN, PH_TURN_CLEAR, PH_EXTRA, PH_TIMED_TURN: begin
        m.pins = turn_left_q ? PINS_LEFT : PINS_RIGHT;
      end
      default: m.pins = PINS_STOP;
    endcase
    m.obstacle = cur_class;
    m.phase_code = seq_phase;
    tick_no = tick_no + 32'd1;
    return m;
  endfunction

  always @(posedge clk) begin : watch
    motion_t want;
    if (!rst_n) begin
      t_short_rev = RST_SHORT_REV;
      t_long_rev = RST_LONG_REV;
      t_extra = RST_EXTRA_TURN;
      t_quarter = RST_QUARTER;
      t_half = RST_HALF;
      t_window = RST_REPEAT_WIN;
      t_settle = RST_SETTLE;
      seq_phase = PH_WAIT;
      phase_left = '0;
      tick_no = '0;
      last_hit = '0;
      prev_class = CL_NONE;
      cur_class = CL_NONE;
      turn_left_q = 1'b0;
      motion_q.delete();
      phases_seen = '0;
      classes_seen = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SHORT_REV: t_short_rev = cfg_data;
          CFG_LONG_REV: t_long_rev = cfg_data;
          CFG_EXTRA_TURN: t_extra = cfg_data;
          CFG_QUARTER: t_quarter = cfg_data;
          CFG_HALF: t_half = cfg_data;
          CFG_REPEAT_WIN: t_window = cfg_data;
          CFG_SETTLE: t_settle = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (motion_q.size() == 0) begin
          report_mismatch($sformatf("result beat %h with nothing expected", out_tdata));
        end else begin
          want = motion_q.pop_front();
          if (out_tdata[7:0] !== want.pins) begin
            report_mismatch($sformatf("tick %0d: motor pins %h, expected %h",
                                      ticks_checked, out_tdata[7:0], want.pins));
          end
          if (out_tdata[11:8] !== want.obstacle) begin
            report_mismatch($sformatf("tick %0d: obstacle class %0d, expected %0d",
                                      ticks_checked, out_tdata[11:8], want.obstacle));
          end
          if (out_tdata[15:12] !== want.phase_code) begin
            report_mismatch($sformatf("tick %0d: phase %0d, expected %0d",
                                      ticks_checked, out_tdata[15:12], want.phase_code));
          end
          ticks_checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        want = predict_motion(in_tdata[5:0]);
        motion_q.push_back(want);
        phases_seen[want.phase_code] = 1'b1;
        classes_seen[want.obstacle] = 1'b1;
      end
    end
    pending = motion_q.size();
  end

endmodule

// ===== sim/tb_obstacle_avoid_motor_sequencer.sv =====
`timescale 1ns / 1ps

module tb_obstacle_avoid_motor_sequencer;
  import oams_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int unsigned SETTLE_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 60;

  localparam logic [5:0] FRONT  = 6'b000001;
  localparam logic [5:0] LEFT   = 6'b000010;
  localparam logic [5:0] RIGHT  = 6'b000100;
  localparam logic [5:0] SIDE_L = 6'b001000;
  localparam logic [5:0] SIDE_R = 6'b010000;
  localparam logic [5:0] BUTTON = 6'b100000;
  localparam logic [5:0] CLEAR  = 6'b000000;

  // Obstacle walk run once the short timings are loaded, first beat highest.
  localparam logic [20:0][5:0] OBSTACLE_WALK = {
    FRONT, CLEAR, CLEAR, CLEAR, CLEAR, CLEAR, CLEAR,
    LEFT, CLEAR, CLEAR, CLEAR,
    RIGHT | SIDE_R, CLEAR, CLEAR, CLEAR, CLEAR, CLEAR,
    FRONT | SIDE_L | SIDE_R,
    FRONT | LEFT | RIGHT | SIDE_L | SIDE_R | BUTTON,
    CLEAR,
    LEFT | RIGHT | SIDE_L
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned mismatches, pending, ticks_checked;
  logic [9:0]  phases_seen;
  logic [8:0]  classes_seen;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned ticks_sent = 0;
  logic [4:0]  scene = '0;
  int unsigned scene_left = 0;

  obstacle_avoid_motor_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  obstacle_avoid_motor_sequencer_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .ticks_checked(ticks_checked),
    .phases_seen  (phases_seen),
    .classes_seen (classes_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, or holds off for a long stretch on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_tick(input logic [5:0] sensors);
    if (ticks_sent < 300) begin
      send_idle_pct = 35;
      recv_idle_pct <= 60;
    end else if (ticks_sent < 600) begin
      send_idle_pct = 60;
      recv_idle_pct <= 35;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct <= 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, sensors};
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
  endtask

  // Obstacle scenes are held for a few ticks so that the until-clear phases
  // see both a blocked and a clear sensor; a share of beats is plain noise.
  task automatic send_random(input int unsigned count);
    int unsigned roll;
    repeat (count) begin
      if (scene_left == 0) begin
        roll = $urandom_range(99);
        if (roll < 45) begin
          scene = '0;
        end else if (roll < 85) begin
          scene[2:0] = 3'($urandom_range(7, 1));
          scene[4:3] = 2'($urandom_range(3));
        end else begin
          scene = 5'($urandom_range(31));
        end
        scene_left = $urandom_range(6, 1);
      end
      scene_left--;
      send_tick({$urandom_range(1) == 1, scene});
    end
  endtask

  task automatic settle_block();
    int unsigned waited;
    waited = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_timings(input logic [15:0] short_rev, input logic [15:0] long_rev,
                              input logic [15:0] extra, input logic [15:0] quarter,
                              input logic [15:0] half, input logic [15:0] window,
                              input logic [15:0] pause);
    write_reg(CFG_SHORT_REV, short_rev);
    write_reg(CFG_LONG_REV, long_rev);
    write_reg(CFG_EXTRA_TURN, extra);
    write_reg(CFG_QUARTER, quarter);
    write_reg(CFG_HALF, half);
    write_reg(CFG_REPEAT_WIN, window);
    write_reg(CFG_SETTLE, pause);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Sensors are ignored until the button is seen.
    send_tick(FRONT | LEFT | RIGHT | SIDE_L | SIDE_R);
    send_tick(CLEAR);
    send_tick(BUTTON);
    send_tick(BUTTON);
    settle_block();

    load_timings(16'd1, 16'd2, 16'd0, 16'd3, 16'd1, 16'd10, 16'd2);
    for (int i = 20; i >= 0; i--) begin
      send_tick(OBSTACLE_WALK[i]);
    end
    send_random(230);
    settle_block();

    load_timings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_random(200);
    settle_block();

    write_reg(CFG_UNUSED, 16'hFFFF);
    load_timings(16'd3, 16'd5, 16'd2, 16'd1, 16'd4, 16'd40, 16'd1);
    hold_req <= hold_req + 1;
    send_random(200);
    settle_block();

    load_timings(16'($urandom_range(8)), 16'($urandom_range(8)), 16'($urandom_range(8)),
                 16'($urandom_range(8)), 16'($urandom_range(8)), 16'($urandom_range(60)),
                 16'($urandom_range(8)));
    hold_req <= hold_req + 1;
    send_random(200);
    settle_block();

    load_timings(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_random(50);
    settle_block();

    $display("Drove %0d sensor ticks under five timing settings, with idle gaps on both sides",
             ticks_sent);
    $display("and two long output hold-offs; %0d results checked, phases %b, classes %b.",
             ticks_checked, phases_seen, classes_seen);
    if (pending != 0) begin
      $display("%0d expected results never arrived.", pending);
    end
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run timed out.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
